### rtl/core/rve_pkg.sv
// Shared types and constants for the rank vector engine.
// Used by the cells, the cell chain and the top level.
package rve_pkg;

  localparam int unsigned DEPTH      = 256;
  localparam int unsigned ELEM_WIDTH = 32;
  localparam int unsigned IDX_W      = $clog2(DEPTH);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned RANK_W     = CNT_W + 1;

  typedef enum logic [3:0] {
    FUNC_READ   = 4'd0,
    FUNC_INSERT = 4'd1,
    FUNC_REMOVE = 4'd2,
    FUNC_FIND   = 4'd3,
    FUNC_SEARCH = 4'd4,
    FUNC_SORT   = 4'd5,
    FUNC_UNIQ   = 4'd6,
    FUNC_DEDUP  = 4'd7,
    FUNC_INV    = 4'd8
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_RANGE = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_SORT   = 2'd3
  } cell_op_e;

  // Broadcast from the sequencer to every cell
  typedef struct packed {
    cell_op_e                      op;
    logic                          hit_key;
    logic                          parity;
    logic [CNT_W-1:0]              lo;
    logic [CNT_W-1:0]              hi;
    logic [CNT_W-1:0]              n;
    logic signed [ELEM_WIDTH-1:0]  key;
  } cell_cmd_t;

  // Travels up the probe chain, one cell per cycle
  typedef struct packed {
    logic                          hit;
    logic [IDX_W-1:0]              rank;
    logic signed [ELEM_WIDTH-1:0]  value;
  } pass_t;

endpackage

### rtl/core/rve_if.sv
// Request and response channel interfaces of the rank vector engine.
// Valid/ready handshake; no package dependency.
interface rve_req_if;
  logic              valid;
  logic              ready;
  logic [3:0]        func;
  logic [8:0]        rank_lo;
  logic [8:0]        rank_hi;
  logic signed [31:0] key_value;

  modport source (output valid, func, rank_lo, rank_hi, key_value, input ready);
  modport sink   (input valid, func, rank_lo, rank_hi, key_value, output ready);
endinterface

interface rve_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [9:0]  found_rank;
  logic signed [31:0] elem_value;
  logic [8:0]         item_count;
  logic [8:0]         array_size;
  logic [1:0]         status;

  modport source (output valid, found_rank, elem_value, item_count, array_size, status,
                  input ready);
  modport sink   (input valid, found_rank, elem_value, item_count, array_size, status,
                  output ready);
endinterface

### rtl/core/rank_vector_engine_core.sv
// Rank vector engine top level: command sequencer over a chain of cells.
// Depends on rve_pkg, rve_if and rve_chain.
//
// Usage: one request on req_i (func, rank_lo, rank_hi, key_value) gives one
// response on rsp_o (found_rank, elem_value, item_count, array_size, status).
// A new request is taken only when the previous one is finished; a finished
// response sits in an output register, so the next request may enter while
// it waits. Every element lives in its own cell. A rank lookup or key match
// travels up the chain one cell per cycle.
// Work per request: insert needs no probe; read, find and inversion count
// take one probe each; remove takes one probe, then shifts out hi-lo
// elements; sort runs odd-even passes; search probes once per halving step,
// up to 9 steps; uniquify and deduplicate probe about twice per element.
// Errors (bad rank, bad range, full) go straight to the response, no change.
// Reset empties the vector at once. If the receiver stalls, the response
// is held and the block finishes at most one more request behind it.
module rank_vector_engine_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  rve_req_if.sink      req_i,
  rve_rsp_if.source    rsp_o
);
  import rve_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PROBE = 6'b000010,
    S_SHIFT = 6'b000100,
    S_SORT  = 6'b001000,
    S_LOOP  = 6'b010000,
    S_FIN   = 6'b100000
  } state_e;

  state_e                    state_q, state_d;
  cell_cmd_t                 cmd_q, cmd_d;
  func_e                     func_q, func_d;
  logic [CNT_W-1:0]          lo_q, lo_d, hi_q, hi_d, n_q, n_d, n0_q, n0_d;
  logic [CNT_W-1:0]          a_q, a_d, b_q, b_d, i_q, i_d, cnt_q, cnt_d;
  logic [CNT_W-1:0]          shift_q, shift_d;
  logic signed [ELEM_WIDTH-1:0] key_q, key_d;
  logic                      phase_q, phase_d;
  logic signed [RANK_W-1:0]  res_rank_q, res_rank_d;
  logic signed [ELEM_WIDTH-1:0] res_val_q, res_val_d;
  logic [CNT_W-1:0]          res_cnt_q, res_cnt_d;
  status_e                   res_stat_q, res_stat_d;

  logic                      out_valid_q, out_valid_d;
  logic signed [RANK_W-1:0]  out_rank_q;
  logic signed [ELEM_WIDTH-1:0] out_val_q;
  logic [CNT_W-1:0]          out_cnt_q, out_size_q;
  status_e                   out_stat_q;
  logic                      out_load;

  pass_t                     pass_top;
  logic [CNT_W-1:0]          cnt_top;
  logic                      range_ok;
  logic [CNT_W-1:0]          req_lo, req_hi;
  logic [CNT_W-1:0]          na, nb;
  logic [RANK_W-1:0]         ab_sum;

  rve_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_q),
    .pass_o (pass_top),
    .cnt_o  (cnt_top)
  );

  assign req_lo   = req_i.rank_lo;
  assign req_hi   = req_i.rank_hi;
  assign range_ok = (req_lo <= req_hi) && (req_hi <= n_q);
  assign req_i.ready = (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    cmd_d      = cmd_q;
    func_d     = func_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    n_d        = n_q;
    n0_d       = n0_q;
    a_d        = a_q;
    b_d        = b_q;
    i_d        = i_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    key_d      = key_q;
    phase_d    = phase_q;
    res_rank_d = res_rank_q;
    res_val_d  = res_val_q;
    res_cnt_d  = res_cnt_q;
    res_stat_d = res_stat_q;
    na         = a_q;
    nb         = b_q;
    ab_sum     = '0;
    out_load   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          func_d     = func_e'(req_i.func);
          lo_d       = req_lo;
          hi_d       = req_hi;
          key_d      = req_i.key_value;
          res_rank_d = '0;
          res_val_d  = '0;
          res_cnt_d  = '0;
          res_stat_d = STAT_OK;
          n0_d       = n_q;
          cnt_d      = '0;
          cmd_d.op   = OP_HOLD;
          cmd_d.n    = n_q;
          state_d    = S_FIN;
          case (func_e'(req_i.func))
            FUNC_READ: begin
              if (req_lo < n_q) begin
                cmd_d.hit_key = 1'b0;
                cmd_d.lo      = req_lo;
                state_d       = S_PROBE;
              end else res_stat_d = STAT_RANGE;
            end
            FUNC_INSERT: begin
              if (n_q >= CNT_W'(DEPTH)) res_stat_d = STAT_FULL;
              else if (req_lo > n_q) res_stat_d = STAT_RANGE;
              else begin
                cmd_d.op   = OP_INSERT;
                cmd_d.lo   = req_lo;
                cmd_d.key  = req_i.key_value;
                n_d        = n_q + 1'b1;
                res_rank_d = RANK_W'(req_lo);
              end
            end
            FUNC_REMOVE: begin
              if (!range_ok) res_stat_d = STAT_RANGE;
              else if (req_hi > req_lo) begin
                cmd_d.hit_key = 1'b0;
                cmd_d.lo      = req_lo;
                state_d       = S_PROBE;
              end
            end
            FUNC_FIND: begin
              if (!range_ok) res_stat_d = STAT_RANGE;
              else begin
                cmd_d.hit_key = 1'b1;
                cmd_d.lo      = req_lo;
                cmd_d.hi      = req_hi;
                cmd_d.key     = req_i.key_value;
                state_d       = S_PROBE;
              end
            end
            FUNC_SEARCH: begin
              if (!range_ok) res_stat_d = STAT_RANGE;
              else if (req_lo < req_hi) begin
                a_d           = req_lo;
                b_d           = req_hi;
                ab_sum        = RANK_W'(req_lo) + RANK_W'(req_hi);
                cmd_d.hit_key = 1'b0;
                cmd_d.lo      = ab_sum[RANK_W-1:1];
                state_d       = S_PROBE;
              end else res_rank_d = $signed(RANK_W'(req_lo)) - RANK_W'(1);
            end
            FUNC_SORT: begin
              if (!range_ok) res_stat_d = STAT_RANGE;
              else begin
                cmd_d.op     = OP_SORT;
                cmd_d.lo     = req_lo;
                cmd_d.hi     = req_hi;
                cmd_d.parity = 1'b0;
                state_d      = S_SORT;
              end
            end
            FUNC_UNIQ, FUNC_DEDUP: begin
              i_d     = CNT_W'(1);
              state_d = S_LOOP;
            end
            FUNC_INV: begin
              state_d = S_PROBE;
            end
            default: ;
          endcase
        end
      end

      S_PROBE: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEPTH)) begin
          cnt_d   = '0;
          state_d = S_FIN;
          case (func_q)
            FUNC_READ: res_val_d = pass_top.value;
            FUNC_REMOVE: begin
              res_val_d = pass_top.value;
              res_cnt_d = hi_q - lo_q;
              cmd_d.op  = OP_SHIFT;
              cmd_d.lo  = lo_q;
              shift_d   = hi_q - lo_q;
              state_d   = S_SHIFT;
            end
            FUNC_FIND: begin
              if (pass_top.hit) res_rank_d = RANK_W'(pass_top.rank);
              else res_rank_d = $signed(RANK_W'(lo_q)) - RANK_W'(1);
            end
            FUNC_SEARCH: begin
              if (key_q < pass_top.value) nb = cmd_q.lo;
              else na = cmd_q.lo + 1'b1;
              a_d = na;
              b_d = nb;
              if (na < nb) begin
                ab_sum   = RANK_W'(na) + RANK_W'(nb);
                cmd_d.lo = ab_sum[RANK_W-1:1];
                state_d  = S_PROBE;
              end else res_rank_d = $signed(RANK_W'(na)) - RANK_W'(1);
            end
            FUNC_INV: res_cnt_d = cnt_top;
            FUNC_UNIQ, FUNC_DEDUP: begin
              if (!phase_q) begin
                // compare element i against its predecessor or all earlier ones
                cmd_d.hit_key = 1'b1;
                cmd_d.key     = pass_top.value;
                cmd_d.lo      = (func_q == FUNC_UNIQ) ? (i_q - 1'b1) : '0;
                cmd_d.hi      = i_q;
                phase_d       = 1'b1;
                state_d       = S_PROBE;
              end else begin
                phase_d = 1'b0;
                if (pass_top.hit) begin
                  cmd_d.op = OP_SHIFT;
                  cmd_d.lo = i_q;
                  shift_d  = CNT_W'(1);
                  state_d  = S_SHIFT;
                end else begin
                  i_d     = i_q + 1'b1;
                  state_d = S_LOOP;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_SHIFT: begin
        shift_d = shift_q - 1'b1;
        n_d     = n_q - 1'b1;
        if (shift_q == CNT_W'(1)) begin
          cmd_d.op = OP_HOLD;
          state_d  = (func_q == FUNC_REMOVE) ? S_FIN : S_LOOP;
        end
      end

      S_SORT: begin
        cmd_d.parity = ~cmd_q.parity;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DEPTH - 1)) begin
          cnt_d    = '0;
          cmd_d.op = OP_HOLD;
          state_d  = S_FIN;
        end
      end

      S_LOOP: begin
        cmd_d.op = OP_HOLD;
        if (i_q < n_q) begin
          cmd_d.hit_key = 1'b0;
          cmd_d.lo      = i_q;
          phase_d       = 1'b0;
          cnt_d         = '0;
          state_d       = S_PROBE;
        end else begin
          res_cnt_d = n0_q - n_q;
          state_d   = S_FIN;
        end
      end

      S_FIN: begin
        cmd_d.op = OP_HOLD;
        if (!out_valid_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (rsp_o.ready) out_valid_d = 1'b0;
    if (out_load) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      n_q         <= '0;
      cnt_q       <= '0;
      phase_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      n_q         <= n_d;
      cnt_q       <= cnt_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q     <= func_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    n0_q       <= n0_d;
    a_q        <= a_d;
    b_q        <= b_d;
    i_q        <= i_d;
    shift_q    <= shift_d;
    key_q      <= key_d;
    res_rank_q <= res_rank_d;
    res_val_q  <= res_val_d;
    res_cnt_q  <= res_cnt_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_rank_q <= res_rank_q;
      out_val_q  <= res_val_q;
      out_cnt_q  <= res_cnt_q;
      out_size_q <= n_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.found_rank = out_rank_q;
  assign rsp_o.elem_value = out_val_q;
  assign rsp_o.item_count = out_cnt_q;
  assign rsp_o.array_size = out_size_q;
  assign rsp_o.status     = out_stat_q;

endmodule

### rtl/core/rve_cell.sv
// One storage cell: holds the element at its rank and one stage of the
// probe and inversion-count chains. Depends on rve_pkg.
module rve_cell (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [rve_pkg::IDX_W-1:0]        idx_i,
  input  rve_pkg::cell_cmd_t               cmd_i,
  input  logic signed [rve_pkg::ELEM_WIDTH-1:0] left_val_i,
  input  logic signed [rve_pkg::ELEM_WIDTH-1:0] right_val_i,
  output logic signed [rve_pkg::ELEM_WIDTH-1:0] val_o,
  input  rve_pkg::pass_t                   pass_i,
  output rve_pkg::pass_t                   pass_o,
  input  logic [rve_pkg::CNT_W-1:0]        cnt_i,
  output logic [rve_pkg::CNT_W-1:0]        cnt_o
);
  import rve_pkg::*;

  logic signed [ELEM_WIDTH-1:0] val_q, val_d;
  pass_t                        pass_q, pass_d;
  logic [CNT_W-1:0]             cnt_q, cnt_d;
  logic [CNT_W-1:0]             idx_w;
  logic                         in_rng, hit, inv, is_left, is_right;

  assign idx_w  = {1'b0, idx_i};
  assign in_rng = (idx_w >= cmd_i.lo) && (idx_w < cmd_i.hi);

  // Odd-even transposition pairs (j, j+1) with j of the given parity
  assign is_left  = (idx_w >= cmd_i.lo) && ((idx_w + 1'b1) < cmd_i.hi)
                    && (idx_i[0] == cmd_i.parity);
  assign is_right = (idx_w > cmd_i.lo) && (idx_w < cmd_i.hi)
                    && (idx_i[0] != cmd_i.parity);

  always_comb begin
    val_d = val_q;
    case (cmd_i.op)
      OP_INSERT: begin
        if (idx_w > cmd_i.lo) val_d = left_val_i;
        else if (idx_w == cmd_i.lo) val_d = cmd_i.key;
      end
      OP_SHIFT: begin
        if (idx_w >= cmd_i.lo) val_d = right_val_i;
      end
      OP_SORT: begin
        if (is_left && (val_q > right_val_i)) val_d = right_val_i;
        else if (is_right && (left_val_i > val_q)) val_d = left_val_i;
      end
      default: val_d = val_q;
    endcase
  end

  assign hit = cmd_i.hit_key ? (in_rng && (val_q == cmd_i.key)) : (idx_w == cmd_i.lo);
  assign inv = (idx_w >= CNT_W'(1)) && (idx_w < cmd_i.n) && (left_val_i > val_q);

  always_comb begin
    if (hit) begin
      pass_d.hit   = 1'b1;
      pass_d.rank  = idx_i;
      pass_d.value = val_q;
    end else begin
      pass_d = pass_i;
    end
    cnt_d = cnt_i + CNT_W'(inv);
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_q <= '0;
      cnt_q  <= '0;
    end else begin
      pass_q <= pass_d;
      cnt_q  <= cnt_d;
    end
  end

  assign val_o  = val_q;
  assign pass_o = pass_q;
  assign cnt_o  = cnt_q;

endmodule

### rtl/core/rve_chain.sv
// Row of DEPTH cells with neighbor links for shifting, sorting and probing.
// Depends on rve_pkg and rve_cell.
module rve_chain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rve_pkg::cell_cmd_t cmd_i,
  output rve_pkg::pass_t     pass_o,
  output logic [rve_pkg::CNT_W-1:0] cnt_o
);
  import rve_pkg::*;

  logic signed [ELEM_WIDTH-1:0] val   [DEPTH];
  pass_t                        pass  [DEPTH];
  logic [CNT_W-1:0]             cnt   [DEPTH];

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ELEM_WIDTH-1:0] left_val, right_val;
    pass_t                        pass_in;
    logic [CNT_W-1:0]             cnt_in;

    if (g == 0) begin : g_first
      assign left_val = val[g];
      assign pass_in  = '0;
      assign cnt_in   = '0;
    end else begin : g_mid
      assign left_val = val[g-1];
      assign pass_in  = pass[g-1];
      assign cnt_in   = cnt[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_val = val[g];
    end else begin : g_inner
      assign right_val = val[g+1];
    end

    rve_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .idx_i       (IDX_W'(g)),
      .cmd_i       (cmd_i),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .val_o       (val[g]),
      .pass_i      (pass_in),
      .pass_o      (pass[g]),
      .cnt_i       (cnt_in),
      .cnt_o       (cnt[g])
    );
  end

  assign pass_o = pass[DEPTH-1];
  assign cnt_o  = cnt[DEPTH-1];

endmodule
